// ===== hw/rtl/mnp_pkg.sv =====
// ----------------------------------------------------------------------------
// mnp_pkg
// Shared types and constants for the MIDI note on/off pairing block.
// ----------------------------------------------------------------------------
`default_nettype none

package mnp_pkg;

  // Number of pitches that keep an open-note entry, and the width of the
  // running tick counter.
  localparam int NUM_PITCHES = 128;
  localparam int TIME_BITS   = 48;

  // Widths fixed by the event and record formats.
  localparam int OP_W      = 2;
  localparam int DELTA_W   = 28;
  localparam int PITCH_W   = 7;
  localparam int VEL_W     = 7;
  localparam int OUT_TIME_W = 48;

  // Table index width follows the number of pitches.
  localparam int IDX_W = (NUM_PITCHES > 1) ? $clog2(NUM_PITCHES) : 1;

  // Event operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_NOTE_ON     = 2'd0,
    OP_NOTE_OFF    = 2'd1,
    OP_DAMPER_DOWN = 2'd2,
    OP_DAMPER_UP   = 2'd3
  } op_t;

  // Record kind codes.
  typedef enum logic {
    REC_NOTE   = 1'b0,
    REC_DAMPER = 1'b1
  } rec_kind_t;

  // Input beat: one event.
  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [DELTA_W-1:0] delta_ticks;
    logic [PITCH_W-1:0] pitch;
    logic [VEL_W-1:0]   velocity;
  } in_beat_t;

  // Output beat: one closed note or damper record.
  typedef struct packed {
    logic                  record_kind;
    logic [PITCH_W-1:0]    note_pitch;
    logic [VEL_W-1:0]      note_volume;
    logic [OUT_TIME_W-1:0] start_ticks;
    logic [OUT_TIME_W-1:0] stop_ticks;
  } out_beat_t;

  // One entry of the open-note table.
  typedef struct packed {
    logic [TIME_BITS-1:0] start;
    logic [VEL_W-1:0]     volume;
  } tbl_entry_t;

  // Access request to the open-note table.
  typedef struct packed {
    logic             write_en;  // note on: open the entry
    logic             read_en;   // note off: read and close the entry
    logic [IDX_W-1:0] idx;
    tbl_entry_t       entry;
  } tbl_req_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mnp_note_table.sv =====
// ----------------------------------------------------------------------------
// mnp_note_table
// Open-note table: a synchronous memory of start time and volume per pitch,
// with an open flag per pitch held in flip-flops that reset clears.
// ----------------------------------------------------------------------------
`default_nettype none

module mnp_note_table (
  input  wire                 clk,
  input  wire                 rst_n,
  input  mnp_pkg::tbl_req_t   req,
  output logic                hit,
  output mnp_pkg::tbl_entry_t rd_entry
);
  import mnp_pkg::*;

  tbl_entry_t             mem [NUM_PITCHES];
  tbl_entry_t             rd_entry_r;
  logic [NUM_PITCHES-1:0] open_r;
  logic [NUM_PITCHES-1:0] open_nxt;

  // The open flag is looked up in the same cycle as the request.
  assign hit = open_r[req.idx];

  // A note on marks the entry open; a note off closes it.
  always_comb begin
    open_nxt = open_r;
    if (req.write_en) begin
      open_nxt[req.idx] = 1'b1;
    end else if (req.read_en) begin
      open_nxt[req.idx] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= '0;
    end else begin
      open_r <= open_nxt;
    end
  end

  // Memory port: one write or one read per cycle, read data registered.
  // An event is either a write or a read, so the two never meet on one entry
  // in the same cycle.
  always_ff @(posedge clk) begin
    if (req.write_en) begin
      mem[req.idx] <= req.entry;
    end
    if (req.read_en) begin
      rd_entry_r <= mem[req.idx];
    end
  end

  assign rd_entry = rd_entry_r;

endmodule

`default_nettype wire

// ===== hw/rtl/midi_note_on_off_pairing.sv =====
// ----------------------------------------------------------------------------
// midi_note_on_off_pairing
// Pairs note-on/note-off and damper-down/damper-up events into records with
// absolute start and stop times in ticks.
// ----------------------------------------------------------------------------
//
//   Port group  Direction  Handshake          Payload
//   in_         input      in_valid/in_stall  in_data  (one event)
//   out_        output     out_valid/out_stall out_data (one record)
//
// One event is taken per clock while in_stall is low. An event that closes
// a note or the damper produces its record through the read stage, where the
// table memory read is registered, and then the output register. Reset clears
// the tick counter, the damper and all open flags at once; no clearing pass is
// needed. A stall on the output holds the record; a second record is held in
// the read stage, and only then does in_stall rise.
`default_nettype none

module midi_note_on_off_pairing (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                in_valid,
  output logic               in_stall,
  input  mnp_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  wire                out_stall,
  output mnp_pkg::out_beat_t out_data
);
  import mnp_pkg::*;

  // Accept and decode.
  logic                 in_acc;
  op_t                  op;
  logic                 pitch_ok;
  logic [TIME_BITS:0]   time_sum;
  logic [TIME_BITS-1:0] time_r;
  logic [TIME_BITS-1:0] time_nxt;
  logic [TIME_BITS-1:0] damper_start_r;
  logic                 damper_open_r;
  tbl_req_t             tbl_req;
  logic                 tbl_hit;
  tbl_entry_t           tbl_rd;
  logic                 note_close;
  logic                 damper_close;

  // Read stage and output register.
  logic                 s1_valid_r;
  logic                 s1_kind_r;
  logic [PITCH_W-1:0]   s1_pitch_r;
  logic [TIME_BITS-1:0] s1_damper_start_r;
  logic [TIME_BITS-1:0] s1_stop_r;
  logic                 out_free;
  logic                 out_valid_r;
  out_beat_t            out_data_r;
  out_beat_t            out_data_nxt;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !out_free;
  assign in_acc   = in_valid && !in_stall;
  assign op       = op_t'(in_data.operation);
  assign pitch_ok = (int'(in_data.pitch) < NUM_PITCHES);

  // Saturating tick accumulator.
  assign time_sum = {1'b0, time_r} + (TIME_BITS + 1)'(in_data.delta_ticks);
  assign time_nxt = time_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : time_sum[TIME_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_r <= '0;
    end else if (in_acc) begin
      time_r <= time_nxt;
    end
  end

  // Table request for note events.
  always_comb begin
    tbl_req              = '0;
    tbl_req.write_en     = in_acc && (op == OP_NOTE_ON) && pitch_ok;
    tbl_req.read_en      = in_acc && (op == OP_NOTE_OFF) && pitch_ok;
    tbl_req.idx          = in_data.pitch[IDX_W-1:0];
    tbl_req.entry.start  = time_nxt;
    tbl_req.entry.volume = in_data.velocity;
  end

  mnp_note_table u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .req      (tbl_req),
    .hit      (tbl_hit),
    .rd_entry (tbl_rd)
  );

  assign note_close   = tbl_req.read_en && tbl_hit;
  assign damper_close = in_acc && (op == OP_DAMPER_UP) && damper_open_r;

  // Damper slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      damper_open_r  <= 1'b0;
      damper_start_r <= '0;
    end else if (in_acc) begin
      if (op == OP_DAMPER_DOWN) begin
        damper_open_r  <= 1'b1;
        damper_start_r <= time_nxt;
      end else if (op == OP_DAMPER_UP) begin
        damper_open_r  <= 1'b0;
      end
    end
  end

  // Read stage: waits for the table data of a closing note.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= note_close || damper_close;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r         <= damper_close ? REC_DAMPER : REC_NOTE;
      s1_pitch_r        <= in_data.pitch;
      s1_damper_start_r <= damper_start_r;
      s1_stop_r         <= time_nxt;
    end
  end

  // Record assembly from the read stage.
  always_comb begin
    out_data_nxt            = '0;
    out_data_nxt.stop_ticks = OUT_TIME_W'(s1_stop_r);
    if (s1_kind_r == REC_DAMPER) begin
      out_data_nxt.record_kind = REC_DAMPER;
      out_data_nxt.start_ticks = OUT_TIME_W'(s1_damper_start_r);
    end else begin
      out_data_nxt.record_kind = REC_NOTE;
      out_data_nxt.note_pitch  = s1_pitch_r;
      out_data_nxt.note_volume = tbl_rd.volume;
      out_data_nxt.start_ticks = OUT_TIME_W'(tbl_rd.start);
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_valid_r) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire
